@@ hdl/mrd_pkg.sv @@
`default_nettype none
package mrd_pkg;

  localparam int PAGE_BITS     = 12;
  localparam int PAGE_NUM_BITS = 24;
  localparam int MAX_ENTRIES   = 16;

  localparam int ADDR_W   = 36;
  localparam int SIZE_W   = 32;
  localparam int CNT_W    = 7;
  localparam int IDX_W    = 6;
  localparam int STATUS_W = 2;

  // page count needs one extra bit: a size near 2^32 rounds up to 2^(32-PAGE_BITS)
  localparam int PG_W   = SIZE_W - PAGE_BITS + 1;
  localparam int BPN_W  = ADDR_W - PAGE_BITS;
  localparam int PN_W   = PAGE_NUM_BITS;
  localparam int CMP_W  = (BPN_W > PG_W) ? BPN_W : PG_W;
  localparam int USED_W = $clog2(MAX_ENTRIES + 1);

  localparam int S_TDATA_W = ((ADDR_W + SIZE_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((IDX_W + 2 * ADDR_W + 7) / 8) * 8;
  localparam int M_PAD_W   = M_TDATA_W - IDX_W - 2 * ADDR_W;

  localparam logic [CNT_W-1:0] ENTRY_COUNT_RST = CNT_W'(8);
  localparam logic [7:0]       MEMTYPE_WB      = 8'h06;
  localparam int               VALID_POS       = 11;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // microprogram addresses
  typedef enum logic [3:0] {
    STEP_WAIT     = 4'd0,
    STEP_CHECK    = 4'd1,
    STEP_AVAIL    = 4'd2,
    STEP_EMIT     = 4'd3,
    STEP_RUN_END  = 4'd4,
    STEP_BAD      = 4'd5,
    STEP_BAD_END  = 4'd6,
    STEP_NOAV     = 4'd7,
    STEP_NOAV_END = 4'd8
  } step_t;

  typedef enum logic [2:0] {
    JC_NO_ACCEPT = 3'd0,
    JC_BAD       = 3'd1,
    JC_NOAV      = 3'd2,
    JC_BUSY      = 3'd3,
    JC_MORE      = 3'd4,
    JC_ALWAYS    = 3'd5
  } jc_t;

  typedef enum logic [1:0] {
    EM_NONE = 2'd0,
    EM_BLK  = 2'd1,
    EM_BAD  = 2'd2,
    EM_NOAV = 2'd3
  } em_t;

  typedef struct packed {
    logic  in_rdy;
    em_t   emit;
    jc_t   jc;
    step_t target;
    step_t nxt;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic bad;
    logic noav;
    logic out_free;
    logic more;
  } flags_t;

endpackage
`default_nettype wire

@@ hdl/mrd_sequencer.sv @@
`default_nettype none
module mrd_sequencer (
  input  wire              clk,
  input  wire              rst,
  input  mrd_pkg::flags_t  flags,
  output mrd_pkg::ctrl_t   ctrl
);

  mrd_pkg::step_t pc;
  mrd_pkg::step_t pc_next;
  logic           taken;

  // control store
  always_comb begin
    unique case (pc)
      mrd_pkg::STEP_WAIT:     ctrl = '{1'b1, mrd_pkg::EM_NONE, mrd_pkg::JC_NO_ACCEPT,
                                       mrd_pkg::STEP_WAIT, mrd_pkg::STEP_CHECK};
      mrd_pkg::STEP_CHECK:    ctrl = '{1'b0, mrd_pkg::EM_NONE, mrd_pkg::JC_BAD,
                                       mrd_pkg::STEP_BAD, mrd_pkg::STEP_AVAIL};
      mrd_pkg::STEP_AVAIL:    ctrl = '{1'b0, mrd_pkg::EM_NONE, mrd_pkg::JC_NOAV,
                                       mrd_pkg::STEP_NOAV, mrd_pkg::STEP_EMIT};
      mrd_pkg::STEP_EMIT:     ctrl = '{1'b0, mrd_pkg::EM_BLK, mrd_pkg::JC_MORE,
                                       mrd_pkg::STEP_EMIT, mrd_pkg::STEP_RUN_END};
      mrd_pkg::STEP_RUN_END:  ctrl = '{1'b0, mrd_pkg::EM_NONE, mrd_pkg::JC_ALWAYS,
                                       mrd_pkg::STEP_WAIT, mrd_pkg::STEP_WAIT};
      mrd_pkg::STEP_BAD:      ctrl = '{1'b0, mrd_pkg::EM_BAD, mrd_pkg::JC_BUSY,
                                       mrd_pkg::STEP_BAD, mrd_pkg::STEP_BAD_END};
      mrd_pkg::STEP_BAD_END:  ctrl = '{1'b0, mrd_pkg::EM_NONE, mrd_pkg::JC_ALWAYS,
                                       mrd_pkg::STEP_WAIT, mrd_pkg::STEP_WAIT};
      mrd_pkg::STEP_NOAV:     ctrl = '{1'b0, mrd_pkg::EM_NOAV, mrd_pkg::JC_BUSY,
                                       mrd_pkg::STEP_NOAV, mrd_pkg::STEP_NOAV_END};
      mrd_pkg::STEP_NOAV_END: ctrl = '{1'b0, mrd_pkg::EM_NONE, mrd_pkg::JC_ALWAYS,
                                       mrd_pkg::STEP_WAIT, mrd_pkg::STEP_WAIT};
      default:                ctrl = '{1'b0, mrd_pkg::EM_NONE, mrd_pkg::JC_ALWAYS,
                                       mrd_pkg::STEP_WAIT, mrd_pkg::STEP_WAIT};
    endcase
  end

  always_comb begin
    unique case (ctrl.jc)
      mrd_pkg::JC_NO_ACCEPT: taken = !flags.in_fire;
      mrd_pkg::JC_BAD:       taken = flags.bad;
      mrd_pkg::JC_NOAV:      taken = flags.noav;
      mrd_pkg::JC_BUSY:      taken = !flags.out_free;
      mrd_pkg::JC_MORE:      taken = flags.more;
      mrd_pkg::JC_ALWAYS:    taken = 1'b1;
      default:               taken = 1'b1;
    endcase
    pc_next = taken ? ctrl.target : ctrl.nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= mrd_pkg::STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    flags.in_fire |=> pc == mrd_pkg::STEP_CHECK)
    else $error("accepted request did not start the check step");

  a_emit_exit: assert property (@(posedge clk) disable iff (rst)
    (pc == mrd_pkg::STEP_EMIT) && !flags.more |=> pc == mrd_pkg::STEP_RUN_END)
    else $error("run did not end after its final beat");
`endif

endmodule
`default_nettype wire

@@ hdl/mrd_datapath.sv @@
`default_nettype none
module mrd_datapath (
  input  wire                                 clk,
  input  wire                                 rst,
  input  mrd_pkg::ctrl_t                      ctrl,
  input  wire [mrd_pkg::CNT_W-1:0]            entry_count,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire [mrd_pkg::S_TDATA_W-1:0]        s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [mrd_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  output logic [mrd_pkg::STATUS_W-1:0]        m_axis_tuser,
  output logic                                m_axis_tlast,
  output mrd_pkg::flags_t                     flags
);

  function automatic logic [mrd_pkg::PG_W-1:0] msb_onehot(
    input logic [mrd_pkg::PG_W-1:0] v
  );
    logic [mrd_pkg::PG_W-1:0] s;
    s = v;
    for (int i = 1; i < mrd_pkg::PG_W; i = i * 2) s = s | (s >> i);
    return s & ~(s >> 1);
  endfunction

  logic [mrd_pkg::ADDR_W-1:0]  in_base;
  logic [mrd_pkg::SIZE_W-1:0]  in_size;
  logic [mrd_pkg::BPN_W-1:0]   in_bpn;
  logic                        in_fire;

  logic [mrd_pkg::PN_W-1:0]    pn;
  logic [mrd_pkg::PG_W-1:0]    pages;
  logic [mrd_pkg::BPN_W-1:0]   maxr;
  logic [mrd_pkg::USED_W-1:0]  used;
  logic                        bad;

  logic [mrd_pkg::USED_W-1:0]  avail;
  logic [mrd_pkg::USED_W-1:0]  used_inc;
  logic                        take_max;
  logic [mrd_pkg::PG_W-1:0]    blk;
  logic [mrd_pkg::PG_W-1:0]    pages_after;
  logic [mrd_pkg::PN_W-1:0]    blk_pn;
  logic [mrd_pkg::PN_W-1:0]    blk_mask;
  logic                        run_full;
  logic                        blk_last;
  logic                        out_free;
  logic                        emit_fire;

  logic                        out_valid;
  logic [mrd_pkg::IDX_W-1:0]   out_idx;
  logic [mrd_pkg::ADDR_W-1:0]  out_bw;
  logic [mrd_pkg::ADDR_W-1:0]  out_mw;
  mrd_pkg::status_t            out_status;
  logic                        out_last;

  assign in_base = s_axis_tdata[mrd_pkg::ADDR_W-1:0];
  assign in_size = s_axis_tdata[mrd_pkg::ADDR_W +: mrd_pkg::SIZE_W];
  assign in_bpn  = in_base[mrd_pkg::ADDR_W-1:mrd_pkg::PAGE_BITS];

  assign s_axis_tready = ctrl.in_rdy;
  assign in_fire       = s_axis_tvalid && ctrl.in_rdy;

  assign avail = (entry_count < mrd_pkg::CNT_W'(mrd_pkg::MAX_ENTRIES))
               ? mrd_pkg::USED_W'(entry_count)
               : mrd_pkg::USED_W'(mrd_pkg::MAX_ENTRIES);

  // block size: the alignment block while it fits, then the top bit of what is left
  assign take_max    = mrd_pkg::CMP_W'(pages) >= mrd_pkg::CMP_W'(maxr);
  assign blk         = take_max ? mrd_pkg::PG_W'(maxr) : msb_onehot(pages);
  assign pages_after = pages - blk;
  assign blk_pn      = mrd_pkg::PN_W'(blk);
  assign blk_mask    = ~(blk_pn - mrd_pkg::PN_W'(1));
  assign used_inc    = used + mrd_pkg::USED_W'(1);
  assign run_full    = used_inc == avail;
  assign blk_last    = run_full || (pages_after == '0);

  assign out_free  = !out_valid || m_axis_tready;
  assign emit_fire = (ctrl.emit != mrd_pkg::EM_NONE) && out_free;

  assign flags.in_fire  = in_fire;
  assign flags.bad      = bad;
  assign flags.noav     = avail == '0;
  assign flags.out_free = out_free;
  assign flags.more     = !out_free || !blk_last;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pn    <= mrd_pkg::PN_W'(in_bpn);
      pages <= mrd_pkg::PG_W'(in_size[mrd_pkg::SIZE_W-1:mrd_pkg::PAGE_BITS])
             + mrd_pkg::PG_W'(|in_size[mrd_pkg::PAGE_BITS-1:0]);
      maxr  <= in_bpn & (~in_bpn + mrd_pkg::BPN_W'(1));
      used  <= '0;
      bad   <= (in_base == '0) || (in_base[mrd_pkg::PAGE_BITS-1:0] != '0)
             || (in_size == '0);
    end else if (emit_fire && (ctrl.emit == mrd_pkg::EM_BLK)) begin
      pn    <= pn + blk_pn;
      pages <= pages_after;
      used  <= used_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      unique case (ctrl.emit)
        mrd_pkg::EM_BLK: begin
          out_idx    <= mrd_pkg::IDX_W'(used);
          out_bw     <= (mrd_pkg::ADDR_W'(pn) << mrd_pkg::PAGE_BITS)
                      | mrd_pkg::ADDR_W'(mrd_pkg::MEMTYPE_WB);
          out_mw     <= (mrd_pkg::ADDR_W'(blk_mask) << mrd_pkg::PAGE_BITS)
                      | (mrd_pkg::ADDR_W'(1) << mrd_pkg::VALID_POS);
          out_status <= run_full ? mrd_pkg::ST_FULL : mrd_pkg::ST_OK;
          out_last   <= blk_last;
        end
        mrd_pkg::EM_BAD: begin
          out_idx    <= '0;
          out_bw     <= '0;
          out_mw     <= '0;
          out_status <= mrd_pkg::ST_BAD;
          out_last   <= 1'b1;
        end
        mrd_pkg::EM_NOAV: begin
          out_idx    <= '0;
          out_bw     <= '0;
          out_mw     <= '0;
          out_status <= mrd_pkg::ST_FULL;
          out_last   <= 1'b1;
        end
        default: begin
          out_idx    <= out_idx;
          out_bw     <= out_bw;
          out_mw     <= out_mw;
          out_status <= out_status;
          out_last   <= out_last;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{mrd_pkg::M_PAD_W{1'b0}}, out_mw, out_bw, out_idx};
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

`ifndef SYNTHESIS
  a_used_below_avail: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit == mrd_pkg::EM_BLK |-> used < avail)
    else $error("block emitted past the available entry count");

  a_blk_pow2_fits: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit == mrd_pkg::EM_BLK |-> $onehot(blk) && (blk <= pages))
    else $error("block is not a power of two within the remaining pages");

  a_ok_last_empty: assert property (@(posedge clk) disable iff (rst)
    emit_fire && (ctrl.emit == mrd_pkg::EM_BLK) && !run_full && blk_last
    |=> pages == '0)
    else $error("run closed ok with pages left over");
`endif

endmodule
`default_nettype wire

@@ hdl/mtrr_range_decomposer.sv @@
`default_nettype none
// Range decomposer: each request beat (page-aligned base, byte size) is turned
// into a run of variable-range base/mask pairs of type write-back that cover
// the region, the size rounded up to whole pages. Blocks start at the largest
// size the base alignment allows and shrink as powers of two. Each result beat
// carries the pair index, the base and mask words, a status (ok, out of
// entries, bad base or size) and tlast on the final beat of the run. A run
// stops early with status out-of-entries once min(entry_count, 16) pairs are
// used. Timing: a small microprogram drives the datapath, one request at a
// time. A request passes accept, two check steps, the emit step (one beat per
// cycle; a stalled output holds it) and return to wait. After the first or
// second check step, a bad request or zero entry count gives one status beat.
// The output register lets the next request be taken while the final beat
// still waits. entry_count is written through cfg_wr_en / cfg_wr_data by the
// user only while idle (the block does not enforce it) and resets to 8.
module mtrr_range_decomposer (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_wr_en,
  input  wire [mrd_pkg::CNT_W-1:0]           cfg_wr_data,   // entry_count
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // region_base[35:0], region_size[67:36], zero pad [71:68]
  input  wire [mrd_pkg::S_TDATA_W-1:0]       s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // entry_index[5:0], base_word[41:6], mask_word[77:42], zero pad [79:78]
  output logic [mrd_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // status[1:0]
  output logic [mrd_pkg::STATUS_W-1:0]       m_axis_tuser,
  output logic                               m_axis_tlast
);

  logic [mrd_pkg::CNT_W-1:0] entry_count;
  mrd_pkg::ctrl_t            ctrl;
  mrd_pkg::flags_t           flags;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= mrd_pkg::ENTRY_COUNT_RST;
    end else if (cfg_wr_en) begin
      entry_count <= cfg_wr_data;
    end
  end

  // program counter and control store
  mrd_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // request registers, block sizing and output register
  mrd_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .entry_count   (entry_count),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .flags         (flags)
  );

endmodule
`default_nettype wire
